[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, quiet while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset cycles included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/u8dc_pkg.sv]
// ----------------------------------------------------------------------------
// u8dc_pkg
// Types and constants shared by the UTF-8 literal decoder and classifier.
// ----------------------------------------------------------------------------
package u8dc_pkg;

  localparam int unsigned CpW = 21;

  // Result error codes.
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_LEAD  = 3'd1,
    ERR_BAD_CONT  = 3'd2,
    ERR_OVERLONG  = 3'd3,
    ERR_RANGE     = 3'd4,
    ERR_SURROGATE = 3'd5,
    ERR_TRUNCATED = 3'd6
  } err_code_t;

  // Running width class of a literal.
  typedef enum logic [1:0] {
    CLS_8  = 2'd0,
    CLS_16 = 2'd1,
    CLS_32 = 2'd2
  } width_cls_t;

  localparam logic [CpW-1:0] CpMax      = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo     = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi     = 21'h00DFFF;
  localparam logic [CpW-1:0] Cls8Max    = 21'h0000FF;
  localparam logic [CpW-1:0] Cls16Max   = 21'h00FFFF;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    logic [CpW-1:0] cp_accum;
    logic [1:0]     bytes_left;
    logic [1:0]     seq_length;
    logic           bad_cont;
    logic           skipping;
    width_cls_t     max_class;
  } dec_state_t;

  // One decoded result beat.
  typedef struct packed {
    logic           valid;
    logic [CpW-1:0] code_point;
    err_code_t      error_code;
    width_cls_t     width_class;
    logic           string_end;
  } dec_result_t;

  // Smallest code point that a sequence of the given length (minus one) may carry.
  function automatic logic [CpW-1:0] min_cp(input logic [1:0] seq);
    logic [CpW-1:0] v;
    unique case (seq)
      2'd0:    v = 21'h000000;
      2'd1:    v = 21'h000080;
      2'd2:    v = 21'h000800;
      default: v = 21'h010000;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/u8dc_in_stage.sv]
// ----------------------------------------------------------------------------
// u8dc_in_stage
// Input register: captures one byte beat and holds it until the decode
// stage consumes it.
// ----------------------------------------------------------------------------
module u8dc_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       take,
  output logic       s1_valid,
  output logic [7:0] s1_byte,
  output logic       s1_last
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;

  // The register is free when empty or when its beat moves on this cycle.
  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload loads on every accepted beat.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;
  assign s1_last  = last_r;

endmodule

[rtl/core/u8dc_step.sv]
// ----------------------------------------------------------------------------
// u8dc_step
// Per-byte decode: from the current state and one byte, forms the next
// state and at most one result.
// ----------------------------------------------------------------------------
module u8dc_step (
  input  u8dc_pkg::dec_state_t  st,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output u8dc_pkg::dec_state_t  st_nxt,
  output u8dc_pkg::dec_result_t res
);
  import u8dc_pkg::*;

  logic [CpW-1:0] cp_cont;
  logic [1:0]     left_cont;
  logic           bad_cont;
  width_cls_t     cls_b;
  width_cls_t     cls_c;
  width_cls_t     max_b;
  width_cls_t     max_c;
  dec_state_t     cleared;

  // Shift in six payload bits of a continuation byte.
  assign cp_cont   = {st.cp_accum[CpW-7:0], data_byte[5:0]};
  assign left_cont = st.bytes_left - 2'd1;
  assign bad_cont  = st.bad_cont || (data_byte[7:6] != 2'b10);

  // Width class of a single-byte character and of an assembled one.
  assign cls_b = CLS_8;
  always_comb begin
    priority if (cp_cont <= Cls8Max) begin
      cls_c = CLS_8;
    end else if (cp_cont <= Cls16Max) begin
      cls_c = CLS_16;
    end else begin
      cls_c = CLS_32;
    end
  end
  assign max_b = (cls_b > st.max_class) ? cls_b : st.max_class;
  assign max_c = (cls_c > st.max_class) ? cls_c : st.max_class;

  always_comb begin
    cleared = '0;
    cleared.max_class = CLS_8;
  end

  always_comb begin
    st_nxt           = st;
    res              = '0;
    res.error_code   = ERR_NONE;
    res.width_class  = st.max_class;
    res.string_end   = 1'b1;

    priority if (st.skipping) begin
      // Drop bytes until the end of the literal.
      if (last_byte) begin
        st_nxt = cleared;
      end
    end else if (st.bytes_left == 2'd0) begin
      // Lead byte.
      priority if (data_byte[7] == 1'b0) begin
        res.valid       = 1'b1;
        res.code_point  = {{(CpW-8){1'b0}}, data_byte};
        res.width_class = max_b;
        res.string_end  = last_byte;
        st_nxt          = cleared;
        if (!last_byte) begin
          st_nxt.max_class = max_b;
        end
      end else if (data_byte[7:5] == 3'b110) begin
        st_nxt.cp_accum   = {{(CpW-5){1'b0}}, data_byte[4:0]};
        st_nxt.seq_length = 2'd1;
        st_nxt.bytes_left = 2'd1;
        st_nxt.bad_cont   = 1'b0;
      end else if (data_byte[7:4] == 4'b1110) begin
        st_nxt.cp_accum   = {{(CpW-4){1'b0}}, data_byte[3:0]};
        st_nxt.seq_length = 2'd2;
        st_nxt.bytes_left = 2'd2;
        st_nxt.bad_cont   = 1'b0;
      end else if (data_byte[7:3] == 5'b11110) begin
        st_nxt.cp_accum   = {{(CpW-3){1'b0}}, data_byte[2:0]};
        st_nxt.seq_length = 2'd3;
        st_nxt.bytes_left = 2'd3;
        st_nxt.bad_cont   = 1'b0;
      end else begin
        res.valid      = 1'b1;
        res.error_code = ERR_BAD_LEAD;
      end
      // A multi-byte lead on the final byte is a truncated sequence.
      if (!res.valid && last_byte) begin
        res.valid      = 1'b1;
        res.error_code = ERR_TRUNCATED;
      end
      if (res.valid && res.error_code != ERR_NONE) begin
        st_nxt          = cleared;
        st_nxt.skipping = !last_byte;
      end
    end else begin
      // Continuation byte.
      st_nxt.cp_accum   = cp_cont;
      st_nxt.bytes_left = left_cont;
      st_nxt.bad_cont   = bad_cont;
      if (left_cont != 2'd0) begin
        if (last_byte) begin
          res.valid      = 1'b1;
          res.error_code = ERR_TRUNCATED;
        end
      end else begin
        res.valid = 1'b1;
        priority if (bad_cont) begin
          res.error_code = ERR_BAD_CONT;
        end else if (cp_cont < min_cp(st.seq_length)) begin
          res.error_code = ERR_OVERLONG;
        end else if (cp_cont > CpMax) begin
          res.error_code = ERR_RANGE;
        end else if (cp_cont >= SurrLo && cp_cont <= SurrHi) begin
          res.error_code = ERR_SURROGATE;
        end else begin
          res.error_code = ERR_NONE;
        end
      end
      if (res.valid) begin
        if (res.error_code != ERR_NONE) begin
          st_nxt          = cleared;
          st_nxt.skipping = !last_byte;
        end else begin
          res.code_point  = cp_cont;
          res.width_class = max_c;
          res.string_end  = last_byte;
          st_nxt          = cleared;
          if (!last_byte) begin
            st_nxt.max_class = max_c;
          end
        end
      end
    end
  end

endmodule

[rtl/core/utf8_string_decode_classify_top.sv]
// ----------------------------------------------------------------------------
// utf8_string_decode_classify_top
// UTF-8 string literal decoder with error checks and a running width class.
// ----------------------------------------------------------------------------
// The block takes one byte beat per clock and, with the sink ready, keeps
// that rate indefinitely. A byte sits in the input register while the decode
// logic forms the next sequence state and its result in the same cycle, and
// the result is loaded into the result register once that register is free.
// The result beat is then presented from the result register and is taken
// while out_tready is high. The decode step forms the next state from each
// held byte combinationally, which is what sets the one byte per clock rate;
// a stalled result holds the input register, and out_tready reaches in_tready
// through logic only. Bytes that only open or continue a sequence, or that
// fall in the skipped tail after an error, give no result beat.
module utf8_string_decode_classify_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic [4:0]  out_tuser,  // [2:0] error_code, [4:3] width_class
  output logic        out_tlast   // string_end
);
  import u8dc_pkg::*;

  `include "assert_macros.svh"

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        take;
  dec_state_t  st_r;
  dec_state_t  st_nxt;
  dec_result_t res;
  logic        out_valid_r;
  logic        out_valid_nxt;
  dec_result_t out_r;

  // The held byte moves on when the result register can take its beat.
  assign take = s1_valid && (!out_valid_r || out_tready);

  u8dc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .take      (take),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte),
    .s1_last   (s1_last)
  );

  u8dc_step u_step (
    .st        (st_r),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  // Decoder state; all zero is the start of a literal in the eight-bit class.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (take) begin
      st_r <= st_nxt;
    end
  end

  // Result register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = res.valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take && res.valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.code_point};
  assign out_tuser  = {out_r.width_class, out_r.error_code};
  assign out_tlast  = out_r.string_end;

  // An error beat carries no code point and always closes the literal.
  `ASSERT_CLK(a_err_beat, out_valid_r && out_r.error_code != ERR_NONE |-> out_r.code_point == '0 && out_r.string_end, "error beat with code point or open literal")

  // While skipping, the sequence state and class are already cleared.
  `ASSERT_CLK(a_skip_clear, st_r.skipping |-> st_r.bytes_left == 2'd0 && st_r.cp_accum == '0 && st_r.max_class == CLS_8, "skip state not cleared")

  // Bytes still expected never exceed the sequence length.
  `ASSERT_CLK(a_left_le_len, st_r.bytes_left <= st_r.seq_length, "bytes_left above seq_length")

  // A supplementary-plane character forces the widest class.
  `ASSERT_CLK(a_wide_class, out_valid_r && out_r.error_code == ERR_NONE && out_r.code_point > Cls16Max |-> out_r.width_class == CLS_32, "width class below code point")

endmodule

[tb/sv/utf8_string_decode_classify_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_string_decode_classify_top_tb
// Self-checking bench for the UTF-8 literal decoder and classifier. Byte beats
// are driven as whole literals: a short directed set first, then random
// literals that are mostly well formed, with injected error sequences. A
// scoreboard decodes every accepted byte on its own and compares each result
// beat with the oldest predicted one.
// ----------------------------------------------------------------------------
import u8dc_pkg::*;

// Tracks the decoder state per accepted byte and holds the predicted results.
class utf8_scoreboard;
  typedef struct {
    logic [CpW-1:0] cp;
    err_code_t      err;
    width_cls_t     cls;
    logic           last;
  } char_result_t;

  char_result_t   pending_chars[$];
  int             mismatch_cnt;

  logic [CpW-1:0] acc;
  logic [1:0]     left;
  logic [1:0]     seq_len;
  bit             bad_cont;
  bit             skipping;
  width_cls_t     max_cls;

  function new();
    mismatch_cnt = 0;
    restart();
  endfunction

  // Start of a fresh literal.
  function void restart();
    acc      = '0;
    left     = 2'd0;
    seq_len  = 2'd0;
    bad_cont = 1'b0;
    skipping = 1'b0;
    max_cls  = CLS_8;
  endfunction

  // Queues one predicted result behind the older ones.
  function void queue_result(char_result_t r);
    pending_chars.insert(pending_chars.size(), r);
  endfunction

  // An error closes the literal; the rest of it is skipped unless this was the last byte.
  function void push_error(err_code_t code, logic l);
    char_result_t r;
    r.cp   = '0;
    r.err  = code;
    r.cls  = max_cls;
    r.last = 1'b1;
    queue_result(r);
    restart();
    skipping = !l;
  endfunction

  function void push_char(logic [CpW-1:0] cp, logic l);
    char_result_t r;
    width_cls_t   c;
    if (cp <= Cls8Max) c = CLS_8;
    else if (cp <= Cls16Max) c = CLS_16;
    else c = CLS_32;
    if (c > max_cls) max_cls = c;
    r.cp   = cp;
    r.err  = ERR_NONE;
    r.cls  = max_cls;
    r.last = l;
    queue_result(r);
    acc      = '0;
    left     = 2'd0;
    seq_len  = 2'd0;
    bad_cont = 1'b0;
    if (l) restart();
  endfunction

  // Advances the decoder by one accepted byte beat.
  function void note_byte(logic [7:0] b, logic l);
    logic [CpW-1:0] floor_cp;
    if (skipping) begin
      if (l) restart();
      return;
    end
    // Lead byte position.
    if (left == 2'd0) begin
      if (!b[7]) begin
        push_char({13'd0, b}, l);
        return;
      end
      if (b[7:5] == 3'b110) begin
        acc     = {16'd0, b[4:0]};
        seq_len = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc     = {17'd0, b[3:0]};
        seq_len = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        acc     = {18'd0, b[2:0]};
        seq_len = 2'd3;
      end else begin
        push_error(ERR_BAD_LEAD, l);
        return;
      end
      left     = seq_len;
      bad_cont = 1'b0;
      if (l) push_error(ERR_TRUNCATED, l);
      return;
    end
    // Continuation byte: content is judged only once the sequence is complete.
    if (b[7:6] != 2'b10) bad_cont = 1'b1;
    acc  = {acc[14:0], b[5:0]};
    left = left - 2'd1;
    if (left != 2'd0) begin
      if (l) push_error(ERR_TRUNCATED, l);
      return;
    end
    case (seq_len)
      2'd1:    floor_cp = 21'h000080;
      2'd2:    floor_cp = 21'h000800;
      default: floor_cp = 21'h010000;
    endcase
    if (bad_cont) push_error(ERR_BAD_CONT, l);
    else if (acc < floor_cp) push_error(ERR_OVERLONG, l);
    else if (acc > CpMax) push_error(ERR_RANGE, l);
    else if (acc >= SurrLo && acc <= SurrHi) push_error(ERR_SURROGATE, l);
    else push_char(acc, l);
  endfunction

  // Compares one result beat with the oldest prediction.
  function void check_char(logic [CpW-1:0] cp, logic [2:0] err, logic [1:0] cls, logic last);
    char_result_t e;
    if (pending_chars.size() == 0) begin
      $display("%0t: result beat with none predicted: cp=%h err=%0d cls=%0d end=%b",
               $time, cp, err, cls, last);
      mismatch_cnt++;
      return;
    end
    e = pending_chars.pop_front();
    if (cp !== e.cp) begin
      $display("%0t: code_point expected %h actual %h", $time, e.cp, cp);
      mismatch_cnt++;
    end
    if (err !== e.err) begin
      $display("%0t: error_code expected %0d actual %0d", $time, e.err, err);
      mismatch_cnt++;
    end
    if (cls !== e.cls) begin
      $display("%0t: width_class expected %0d actual %0d", $time, e.cls, cls);
      mismatch_cnt++;
    end
    if (last !== e.last) begin
      $display("%0t: string_end expected %b actual %b", $time, e.last, last);
      mismatch_cnt++;
    end
  endfunction
endclass

module utf8_string_decode_classify_top_tb;

  localparam int ByteTarget = 900;
  localparam int CalmAfter  = 800;
  localparam int IdleLimit  = 2000;

  // Directed literals; bit 8 flags the last byte of each literal.
  localparam logic [8:0] WARMUP [28] = '{
    // ASCII extremes, smallest two-byte form, largest four-byte form.
    9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,
    // Just above the code space.
    9'h0F4, 9'h090, 9'h080, 9'h180,
    // Surrogate.
    9'h0ED, 9'h0A0, 9'h180,
    // Overlong two-byte lead, then a skipped tail.
    9'h0C1, 9'h0BF, 9'h100,
    // Truncated while a continuation was also bad.
    9'h0E2, 9'h141,
    // Bad continuation on the completing byte.
    9'h0C2, 9'h17F,
    // Bad lead in both ranges, the second one skipped.
    9'h080, 9'h1FF,
    // Lead byte flagged last.
    9'h1C2,
    // Smallest three-byte form.
    9'h0E0, 9'h0A0, 9'h180
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        out_tlast;

  utf8_scoreboard board = new();
  logic [7:0]     lit[$];
  int             sent_cnt = 0;
  bit             calm = 1'b0;
  bit             tx_choppy = 1'b0;
  bit             rx_choppy = 1'b1;

  utf8_string_decode_classify_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drives one byte beat from a falling edge, waits for its acceptance, then may idle.
  task automatic send_byte(input logic [7:0] d, input logic l);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    board.note_byte(d, l);
    sent_cnt++;
    calm = (sent_cnt >= CalmAfter);
    @(negedge clk);
    if (!calm && tx_choppy && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  // Appends one byte to the literal under construction.
  function automatic void add_byte(logic [7:0] b);
    lit.insert(lit.size(), b);
  endfunction

  // Appends the encoding of cp in len bytes, overlong or out of range if asked.
  function automatic void push_utf8(logic [CpW-1:0] cp, int len);
    case (len)
      1: add_byte({1'b0, cp[6:0]});
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // Random literal: mostly valid characters, some error sequences and noise.
  task automatic build_literal();
    int             kind;
    int             len;
    int             idx;
    logic [CpW-1:0] cp;
    logic [7:0]     junk;
    lit.delete();
    repeat ($urandom_range(1, 6)) begin
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      if (kind < 72) begin
        case (len)
          1: cp = CpW'($urandom_range(0, 'h7F));
          2: cp = CpW'($urandom_range('h80, 'h7FF));
          3: begin
            cp = CpW'($urandom_range('h800, 'hFFFF));
            if (cp >= SurrLo && cp <= SurrHi) cp ^= 21'h008000;
          end
          default: cp = CpW'($urandom_range('h10000, 'h10FFFF));
        endcase
        push_utf8(cp, len);
      end else if (kind < 77) begin
        // Overlong: a value that fits a shorter form.
        len = $urandom_range(2, 4);
        cp  = CpW'($urandom_range(0, (len == 2) ? 'h7F : ((len == 3) ? 'h7FF : 'hFFFF)));
        push_utf8(cp, len);
      end else if (kind < 81) begin
        push_utf8(CpW'($urandom_range(SurrLo, SurrHi)), 3);
      end else if (kind < 85) begin
        push_utf8(CpW'($urandom_range('h110000, 'h1FFFFF)), 4);
      end else if (kind < 90) begin
        if ($urandom_range(0, 1)) add_byte(8'($urandom_range('h80, 'hBF)));
        else add_byte(8'($urandom_range('hF8, 'hFF)));
      end else if (kind < 95) begin
        // One continuation byte loses its 10xxxxxx pattern.
        len  = $urandom_range(2, 4);
        cp   = CpW'($urandom_range(0, 'h1FFFFF));
        push_utf8(cp, len);
        junk = 8'($urandom_range(0, 255));
        if (junk[7:6] == 2'b10) junk[6] = 1'b1;
        idx  = lit.size() - $urandom_range(1, len - 1);
        lit[idx] = junk;
      end else begin
        add_byte(8'($urandom_range(0, 255)));
      end
    end
    // Sometimes cut the tail so the literal may end inside a sequence.
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 2)) if (lit.size() > 1) void'(lit.pop_back());
    end
  endtask

  // Result side: stall bursts while choppy, none near the end.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) rx_choppy = !rx_choppy;
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!calm && rx_choppy && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 11);
      end
    end
  end

  // Each accepted result beat is checked against the prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_char(out_tdata[CpW-1:0], out_tuser[2:0], out_tuser[4:3], out_tlast);
  end

  // Ends the run when no beat moves on either side for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    bit drained;
    drained = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_choppy = 1'($urandom_range(0, 1));
    foreach (WARMUP[i]) send_byte(WARMUP[i][7:0], WARMUP[i][8]);

    while (sent_cnt < ByteTarget) begin
      // Once mid-run, hold the input until every predicted result is out.
      if (!drained && sent_cnt >= ByteTarget / 2) begin
        drained = 1'b1;
        if (board.pending_chars.size() != 0) begin
          in_tvalid <= 1'b0;
          while (board.pending_chars.size() != 0) @(negedge clk);
        end
      end
      build_literal();
      tx_choppy = 1'($urandom_range(0, 1));
      foreach (lit[i]) send_byte(lit[i], i == lit.size() - 1);
    end
    in_tvalid <= 1'b0;

    // Drain, then leave room for any stray beat.
    while (board.pending_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
